// File: rtl/bsnw_pkg.sv
// bsnw_pkg: shared types, codes and spline coefficient tables for the
// b-spline node weight/gradient core. no dependencies.
`default_nettype none
package bsnw_pkg;

  localparam int DEF_INDEX_BITS = 10;
  localparam int DEF_FRAC_BITS  = 16;

  typedef enum logic [2:0] {
    CFG_LOW_X  = 3'd0,
    CFG_HIGH_X = 3'd1,
    CFG_LOW_Y  = 3'd2,
    CFG_HIGH_Y = 3'd3,
    CFG_LOW_Z  = 3'd4,
    CFG_HIGH_Z = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_NODE,
    ST_MUL,
    ST_ADD,
    ST_DIV1,
    ST_DIV2,
    ST_EMIT,
    ST_REJECT,
    ST_DRAIN
  } state_t;

  // spline pieces: interior, near boundary, boundary
  localparam logic [3:0] PC_INT0 = 4'd0;
  localparam logic [3:0] PC_INT1 = 4'd1;
  localparam logic [3:0] PC_INT2 = 4'd2;
  localparam logic [3:0] PC_INT3 = 4'd3;
  localparam logic [3:0] PC_NB0  = 4'd4;
  localparam logic [3:0] PC_NB1  = 4'd5;
  localparam logic [3:0] PC_NB2  = 4'd6;
  localparam logic [3:0] PC_BD0  = 4'd7;
  localparam logic [3:0] PC_BD1  = 4'd8;

  typedef logic signed [3:0][7:0] coef_row_t;

  typedef struct packed {
    logic       load;
    logic       node_init;
    logic       mul;
    logic       add;
    logic       div1;
    logic       div2;
    logic       emit;
    logic       reject;
    logic       last;
    logic [1:0] axis;
    logic [1:0] n;
    logic [1:0] step;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] k;
  } cmd_t;

  typedef struct packed {
    logic            oor;
    logic [2:0][2:0] cnt;
    logic            pipe_busy;
  } status_t;

  // 12 * weight polynomial, highest power in row[3]
  function automatic coef_row_t poly_w(input logic [3:0] p);
    coef_row_t r;
    case (p)
      PC_INT0: r = {8'sd2, 8'sd12, 8'sd24, 8'sd16};
      PC_INT1: r = {-8'sd6, -8'sd12, 8'sd0, 8'sd8};
      PC_INT2: r = {8'sd6, -8'sd12, 8'sd0, 8'sd8};
      PC_INT3: r = {-8'sd2, 8'sd12, -8'sd24, 8'sd16};
      PC_NB0:  r = {-8'sd11, -8'sd15, 8'sd3, 8'sd7};
      PC_NB1:  r = {8'sd7, -8'sd15, 8'sd3, 8'sd7};
      PC_NB2:  r = {-8'sd2, 8'sd12, -8'sd24, 8'sd16};
      PC_BD0:  r = {8'sd9, -8'sd18, 8'sd0, 8'sd12};
      PC_BD1:  r = {-8'sd3, 8'sd18, -8'sd36, 8'sd24};
      default: r = '0;
    endcase
    return r;
  endfunction

  // 12 * gradient polynomial
  function automatic coef_row_t poly_g(input logic [3:0] p);
    coef_row_t r;
    case (p)
      PC_INT0: r = {8'sd0, 8'sd6, 8'sd24, 8'sd24};
      PC_INT1: r = {8'sd0, -8'sd18, -8'sd24, 8'sd0};
      PC_INT2: r = {8'sd0, 8'sd18, -8'sd24, 8'sd0};
      PC_INT3: r = {8'sd0, -8'sd6, 8'sd24, -8'sd24};
      PC_NB0:  r = {8'sd0, -8'sd33, -8'sd30, 8'sd3};
      PC_NB1:  r = {8'sd0, 8'sd21, -8'sd30, 8'sd3};
      PC_NB2:  r = {8'sd0, -8'sd6, 8'sd24, -8'sd24};
      PC_BD0:  r = {8'sd0, 8'sd27, -8'sd36, 8'sd0};
      PC_BD1:  r = {8'sd0, -8'sd9, 8'sd36, -8'sd36};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/bspline_node_weight_gradient_core.sv
// bspline_node_weight_gradient_core: top level, controller plus datapath.
// depends on bsnw_pkg, bsnw_ctrl and bsnw_datapath.
//
// A particle is taken when start is high and busy is low. Each axis node
// (2 to 4 per axis, up to 12) is evaluated in turn on a shared horner
// and divide-by-12 sequence, then one result per node of the 3d product
// leaves per cycle through a 3-stage multiply pipeline, x outermost, z
// innermost, last_node on the final one. A rejected particle gives a
// single out_of_range result. Results carry out_valid for one cycle and
// cannot be held off.
`default_nettype none
module bspline_node_weight_gradient_core import bsnw_pkg::*; #(
  parameter int INDEX_BITS = DEF_INDEX_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [2:0]                      cfg_index,
  input  wire logic [INDEX_BITS:0]             cfg_data,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [INDEX_BITS+FRAC_BITS-1:0] in_pos_x,
  input  wire logic [INDEX_BITS+FRAC_BITS-1:0] in_pos_y,
  input  wire logic [INDEX_BITS+FRAC_BITS-1:0] in_pos_z,
  output logic                                 out_valid,
  output logic [INDEX_BITS-1:0]                out_node_x,
  output logic [INDEX_BITS-1:0]                out_node_y,
  output logic [INDEX_BITS-1:0]                out_node_z,
  output logic [FRAC_BITS:0]                   out_weight,
  output logic signed [FRAC_BITS+2:0]          out_grad_x,
  output logic signed [FRAC_BITS+2:0]          out_grad_y,
  output logic signed [FRAC_BITS+2:0]          out_grad_z,
  output logic                                 out_last_node,
  output logic                                 out_out_of_range
);

  cmd_t    cmd;
  status_t status;

  bsnw_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  bsnw_datapath #(
    .INDEX_BITS (INDEX_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_node_x       (out_node_x),
    .out_node_y       (out_node_y),
    .out_node_z       (out_node_z),
    .out_weight       (out_weight),
    .out_grad_x       (out_grad_x),
    .out_grad_y       (out_grad_y),
    .out_grad_z       (out_grad_z),
    .out_last_node    (out_last_node),
    .out_out_of_range (out_out_of_range)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted beat did not raise busy");

  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_last_node && out_weight == 0)
    else $error("rejected result not marked last or not zero");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_node |=> !out_valid)
    else $error("result beat right after last node");

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> busy) else $error("emit issued while idle");

endmodule
`default_nettype wire

// File: rtl/bsnw_ctrl.sv
// bsnw_ctrl: sequencer for node evaluation and result emission.
// depends on bsnw_pkg.
`default_nettype none
module bsnw_ctrl import bsnw_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt, n_r, n_nxt, step_r, step_nxt;
  logic [1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [2:0] cnt_a, cx, cy, cz;
  logic       last;

  assign cx = status.cnt[0];
  assign cy = status.cnt[1];
  assign cz = status.cnt[2];

  always_comb begin
    case (axis_r)
      2'd0:    cnt_a = cx;
      2'd1:    cnt_a = cy;
      default: cnt_a = cz;
    endcase
  end

  assign last = ({1'b0, i_r} == cx - 3'd1) && ({1'b0, j_r} == cy - 3'd1) &&
                ({1'b0, k_r} == cz - 3'd1);
  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = status.oor ? ST_REJECT : ST_NODE;
      ST_NODE:   state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_ADD;
      ST_ADD:    state_nxt = (step_r == 2'd2) ? ST_DIV1 : ST_MUL;
      ST_DIV1:   state_nxt = ST_DIV2;
      ST_DIV2: begin
        if ({1'b0, n_r} + 3'd1 == cnt_a && axis_r == 2'd2) state_nxt = ST_EMIT;
        else state_nxt = ST_NODE;
      end
      ST_EMIT:   if (last) state_nxt = ST_DRAIN;
      ST_REJECT: state_nxt = ST_DRAIN;
      ST_DRAIN:  if (!status.pipe_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    axis_nxt = axis_r;
    n_nxt    = n_r;
    step_nxt = step_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    k_nxt    = k_r;
    case (state_r)
      ST_CHECK: begin
        axis_nxt = 2'd0;
        n_nxt    = 2'd0;
        i_nxt    = 2'd0;
        j_nxt    = 2'd0;
        k_nxt    = 2'd0;
      end
      ST_NODE: step_nxt = 2'd0;
      ST_ADD:  step_nxt = step_r + 2'd1;
      ST_DIV2: begin
        if ({1'b0, n_r} + 3'd1 == cnt_a) begin
          n_nxt    = 2'd0;
          axis_nxt = axis_r + 2'd1;
        end else begin
          n_nxt = n_r + 2'd1;
        end
      end
      ST_EMIT: begin
        if ({1'b0, k_r} + 3'd1 == cz) begin
          k_nxt = 2'd0;
          if ({1'b0, j_r} + 3'd1 == cy) begin
            j_nxt = 2'd0;
            i_nxt = i_r + 2'd1;
          end else begin
            j_nxt = j_r + 2'd1;
          end
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.axis      = axis_r;
    cmd.n         = n_r;
    cmd.step      = step_r;
    cmd.i         = i_r;
    cmd.j         = j_r;
    cmd.k         = k_r;
    cmd.last      = last;
    case (state_r)
      ST_IDLE:   cmd.load = start;
      ST_NODE:   cmd.node_init = 1'b1;
      ST_MUL:    cmd.mul = 1'b1;
      ST_ADD:    cmd.add = 1'b1;
      ST_DIV1:   cmd.div1 = 1'b1;
      ST_DIV2:   cmd.div2 = 1'b1;
      ST_EMIT:   cmd.emit = 1'b1;
      ST_REJECT: begin
        cmd.emit   = 1'b1;
        cmd.reject = 1'b1;
        cmd.last   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
      n_r     <= '0;
      step_r  <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      n_r     <= n_nxt;
      step_r  <= step_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/bsnw_datapath.sv
// bsnw_datapath: config registers, per-axis spline evaluation with horner
// steps and divide by 12, axis tables and the result product pipeline.
// depends on bsnw_pkg.
`default_nettype none
module bsnw_datapath import bsnw_pkg::*; #(
  parameter int INDEX_BITS = DEF_INDEX_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [2:0]                     cfg_index,
  input  wire logic [INDEX_BITS:0]            cfg_data,
  input  wire logic [INDEX_BITS+FRAC_BITS-1:0] in_pos_x,
  input  wire logic [INDEX_BITS+FRAC_BITS-1:0] in_pos_y,
  input  wire logic [INDEX_BITS+FRAC_BITS-1:0] in_pos_z,
  input  wire cmd_t                           cmd,
  output status_t                             status,
  output logic                                out_valid,
  output logic [INDEX_BITS-1:0]               out_node_x,
  output logic [INDEX_BITS-1:0]               out_node_y,
  output logic [INDEX_BITS-1:0]               out_node_z,
  output logic [FRAC_BITS:0]                  out_weight,
  output logic signed [FRAC_BITS+2:0]         out_grad_x,
  output logic signed [FRAC_BITS+2:0]         out_grad_y,
  output logic signed [FRAC_BITS+2:0]         out_grad_z,
  output logic                                out_last_node,
  output logic                                out_out_of_range
);

  localparam int IB  = INDEX_BITS;
  localparam int FB  = FRAC_BITS;
  localparam int PW  = IB + FB;
  localparam int NW  = IB + 2;
  localparam int TFW = NW + FB + 1;
  localparam int TW  = FB + 3;
  localparam int AW  = FB + 10;
  localparam int PRW = AW + TW;
  localparam int UW  = FB + 13;
  localparam int WW  = FB + 2;
  localparam int P1W = 2 * WW;
  localparam int R1W = FB + 4;
  localparam int P2W = R1W + WW;
  localparam int R2W = FB + 6;

  localparam logic signed [TFW-1:0] T_TWO   = TFW'(1) << (FB + 1);
  localparam logic signed [TW-1:0]  T_ONE   = TW'(1) << FB;
  localparam logic signed [PRW-1:0] HALF_PR = PRW'(1) << (FB - 1);
  localparam logic signed [P1W-1:0] HALF_P1 = P1W'(1) << (FB - 1);
  localparam logic signed [P2W-1:0] HALF_P2 = P2W'(1) << (FB - 1);
  localparam logic [UW-1:0]         DIV_OFFQ = UW'(1) << (FB + 9);
  localparam logic [UW-1:0]         DIV_OFF  = UW'(12) << (FB + 9);
  localparam logic [UW-1:0]         DIV_K    = UW'((64'd1 << UW) / 64'd12);
  localparam logic signed [UW:0]    Q_ONE    = (UW + 1)'(1) << FB;
  localparam logic signed [R2W-1:0] W_MAX    = (R2W'(1) << (FB + 1)) - R2W'(1);
  localparam logic signed [R2W-1:0] G_MAX    = (R2W'(1) << (FB + 2)) - R2W'(1);
  localparam logic signed [R2W-1:0] G_MIN    = -(R2W'(1) << (FB + 2));

  logic [PW-1:0] pos_r [3];
  logic [IB-1:0] lo_r  [3];
  logic [IB:0]   hi_r  [3];

  // axis floor, range and node count
  logic [NW-1:0]      ix [3];
  logic [2:0]         oor_a;
  logic [2:0][2:0]    cnt_w;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ix[a]    = NW'(pos_r[a][PW-1:FB]);
      oor_a[a] = (ix[a] < NW'(lo_r[a])) || (ix[a] + NW'(2) > NW'(hi_r[a]));
      cnt_w[a] = 3'd2 + {2'b0, ix[a] > NW'(lo_r[a])} +
                 {2'b0, ix[a] + NW'(2) < NW'(hi_r[a])};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        lo_r[a] <= '0;
        hi_r[a] <= (IB + 1)'(1) << IB;
      end
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOW_X:  lo_r[0] <= cfg_data[IB-1:0];
        CFG_HIGH_X: hi_r[0] <= cfg_data;
        CFG_LOW_Y:  lo_r[1] <= cfg_data[IB-1:0];
        CFG_HIGH_Y: hi_r[1] <= cfg_data;
        CFG_LOW_Z:  lo_r[2] <= cfg_data[IB-1:0];
        CFG_HIGH_Z: hi_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r[0] <= in_pos_x;
      pos_r[1] <= in_pos_y;
      pos_r[2] <= in_pos_z;
    end
  end

  // node selection and spline kind
  logic [NW-1:0]         nd, ixs, los, his;
  logic [PW-1:0]         poss;
  logic                  lo_gt;
  logic                  mir;
  logic [1:0]            kind;
  logic signed [TFW-1:0] t_raw, t_m;
  logic signed [TW-1:0]  t_c;
  logic [3:0]            piece;

  always_comb begin
    case (cmd.axis)
      2'd0: begin
        ixs = ix[0]; los = NW'(lo_r[0]); his = NW'(hi_r[0]); poss = pos_r[0];
      end
      2'd1: begin
        ixs = ix[1]; los = NW'(lo_r[1]); his = NW'(hi_r[1]); poss = pos_r[1];
      end
      default: begin
        ixs = ix[2]; los = NW'(lo_r[2]); his = NW'(hi_r[2]); poss = pos_r[2];
      end
    endcase
    lo_gt = ixs > los;
    case (cmd.n)
      2'd0:    nd = ixs;
      2'd1:    nd = ixs + NW'(1);
      2'd2:    nd = lo_gt ? ixs - NW'(1) : ixs + NW'(2);
      default: nd = ixs + NW'(2);
    endcase
    mir  = 1'b0;
    kind = 2'd0;
    if (nd == los) kind = 2'd2;
    else if (nd == his - NW'(1)) begin
      kind = 2'd2;
      mir  = 1'b1;
    end else if (nd == los + NW'(1)) kind = 2'd1;
    else if (nd == his - NW'(2)) begin
      kind = 2'd1;
      mir  = 1'b1;
    end
    t_raw = $signed(TFW'(poss)) - $signed(TFW'({nd, {FB{1'b0}}}));
    t_m   = mir ? -t_raw : t_raw;
    if (t_m > T_TWO) t_c = TW'(T_TWO);
    else if (t_m < -T_TWO) t_c = -TW'(T_TWO);
    else t_c = TW'(t_m);
    case (kind)
      2'd0: begin
        if (t_c < -T_ONE) piece = PC_INT0;
        else if (t_c < 0) piece = PC_INT1;
        else if (t_c < T_ONE) piece = PC_INT2;
        else piece = PC_INT3;
      end
      2'd1: begin
        if (t_c < 0) piece = PC_NB0;
        else if (t_c < T_ONE) piece = PC_NB1;
        else piece = PC_NB2;
      end
      default: piece = (t_c < T_ONE) ? PC_BD0 : PC_BD1;
    endcase
  end

  // horner evaluation, weight and gradient chains side by side
  logic signed [TW-1:0]  t_r;
  logic [3:0]            piece_r;
  logic                  mir_r;
  logic [NW-1:0]         nd_r;
  logic signed [AW-1:0]  accw_r, accg_r;
  logic signed [PRW-1:0] prw_r, prg_r;
  logic [UW-1:0]         uw_r, ug_r;
  logic [2*UW-1:0]       mw_r, mg_r;

  coef_row_t             roww, rowg, rowwi, rowgi;
  logic signed [7:0]     cw, cg, cw0, cg0;
  logic signed [PRW-1:0] sw, sg;
  logic signed [AW-1:0]  accw_nxt, accg_nxt, bw, bg;
  logic [UW-1:0]         uw_nxt, ug_nxt;

  always_comb begin
    rowwi    = poly_w(piece);
    rowgi    = poly_g(piece);
    cw0      = rowwi[3];
    cg0      = rowgi[3];
    roww     = poly_w(piece_r);
    rowg     = poly_g(piece_r);
    cw       = roww[2'd2 - cmd.step];
    cg       = rowg[2'd2 - cmd.step];
    sw       = prw_r + HALF_PR;
    sg       = prg_r + HALF_PR;
    accw_nxt = AW'(sw >>> FB) + ({{(AW-8){cw[7]}}, cw} <<< FB);
    accg_nxt = AW'(sg >>> FB) + ({{(AW-8){cg[7]}}, cg} <<< FB);
    bw       = accw_r + AW'(6);
    bg       = accg_r + AW'(6);
    uw_nxt   = {{(UW-AW){bw[AW-1]}}, bw} + DIV_OFF;
    ug_nxt   = {{(UW-AW){bg[AW-1]}}, bg} + DIV_OFF;
  end

  always_ff @(posedge clk) begin
    if (cmd.node_init) begin
      t_r     <= t_c;
      piece_r <= piece;
      mir_r   <= mir;
      nd_r    <= nd;
      accw_r  <= {{(AW-8){cw0[7]}}, cw0} <<< FB;
      accg_r  <= {{(AW-8){cg0[7]}}, cg0} <<< FB;
    end
    if (cmd.mul) begin
      prw_r <= accw_r * t_r;
      prg_r <= accg_r * t_r;
    end
    if (cmd.add) begin
      accw_r <= accw_nxt;
      accg_r <= accg_nxt;
    end
    if (cmd.div1) begin
      uw_r <= uw_nxt;
      ug_r <= ug_nxt;
      mw_r <= uw_nxt * DIV_K;
      mg_r <= ug_nxt * DIV_K;
    end
  end

  // divide by 12 correction and clamp
  logic [UW-1:0]        q0w, q0g, rw, rg, qw, qg;
  logic signed [UW:0]   sqw, sqg, gneg;
  logic signed [WW-1:0] w_fin, g_fin;

  always_comb begin
    q0w  = mw_r[2*UW-1:UW];
    q0g  = mg_r[2*UW-1:UW];
    rw   = uw_r - q0w * UW'(12);
    rg   = ug_r - q0g * UW'(12);
    qw   = q0w + UW'(rw >= UW'(12));
    qg   = q0g + UW'(rg >= UW'(12));
    sqw  = $signed({1'b0, qw}) - $signed({1'b0, DIV_OFFQ});
    sqg  = $signed({1'b0, qg}) - $signed({1'b0, DIV_OFFQ});
    if (sqw < 0) w_fin = '0;
    else if (sqw > Q_ONE) w_fin = WW'(Q_ONE);
    else w_fin = WW'(sqw);
    if (sqg < -Q_ONE) gneg = -Q_ONE;
    else if (sqg > Q_ONE) gneg = Q_ONE;
    else gneg = sqg;
    g_fin = mir_r ? -WW'(gneg) : WW'(gneg);
  end

  logic signed [WW-1:0] wt_r   [3][4];
  logic signed [WW-1:0] gr_r   [3][4];
  logic [IB-1:0]        node_r [3][4];

  always_ff @(posedge clk) begin
    if (cmd.div2) begin
      wt_r[cmd.axis][cmd.n]   <= w_fin;
      gr_r[cmd.axis][cmd.n]   <= g_fin;
      node_r[cmd.axis][cmd.n] <= nd_r[IB-1:0];
    end
  end

  // product pipeline: x*y, then *z, then round and saturate
  logic                  v1_r, v2_r, v3_r;
  logic                  l1_r, l2_r, j1_r, j2_r;
  logic [IB-1:0]         n1x_r, n1y_r, n1z_r, n2x_r, n2y_r, n2z_r;
  logic signed [P1W-1:0] pwxy_r, pgxy_r, pwgy_r;
  logic signed [WW-1:0]  wz1_r, gz1_r;
  logic signed [P2W-1:0] pw_r, pgx_r, pgy_r, pgz_r;
  logic signed [P1W-1:0] s1a, s1b, s1c;
  logic signed [R1W-1:0] rwxy, rgxy, rwgy;
  logic signed [P2W-1:0] s2w, s2x, s2y, s2z;
  logic signed [R2W-1:0] rw2, rgx2, rgy2, rgz2;

  function automatic logic signed [R2W-1:0] sat_g(input logic signed [R2W-1:0] v);
    return (v > G_MAX) ? G_MAX : ((v < G_MIN) ? G_MIN : v);
  endfunction

  always_comb begin
    s1a  = pwxy_r + HALF_P1;
    s1b  = pgxy_r + HALF_P1;
    s1c  = pwgy_r + HALF_P1;
    rwxy = R1W'(s1a >>> FB);
    rgxy = R1W'(s1b >>> FB);
    rwgy = R1W'(s1c >>> FB);
    s2w  = pw_r + HALF_P2;
    s2x  = pgx_r + HALF_P2;
    s2y  = pgy_r + HALF_P2;
    s2z  = pgz_r + HALF_P2;
    rw2  = R2W'(s2w >>> FB);
    rgx2 = R2W'(s2x >>> FB);
    rgy2 = R2W'(s2y >>> FB);
    rgz2 = R2W'(s2z >>> FB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.emit;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    pwxy_r <= wt_r[0][cmd.i] * wt_r[1][cmd.j];
    pgxy_r <= gr_r[0][cmd.i] * wt_r[1][cmd.j];
    pwgy_r <= wt_r[0][cmd.i] * gr_r[1][cmd.j];
    wz1_r  <= wt_r[2][cmd.k];
    gz1_r  <= gr_r[2][cmd.k];
    n1x_r  <= node_r[0][cmd.i];
    n1y_r  <= node_r[1][cmd.j];
    n1z_r  <= node_r[2][cmd.k];
    l1_r   <= cmd.last;
    j1_r   <= cmd.reject;

    pw_r  <= rwxy * wz1_r;
    pgx_r <= rgxy * wz1_r;
    pgy_r <= rwgy * wz1_r;
    pgz_r <= rwxy * gz1_r;
    n2x_r <= n1x_r;
    n2y_r <= n1y_r;
    n2z_r <= n1z_r;
    l2_r  <= l1_r;
    j2_r  <= j1_r;

    out_last_node    <= l2_r;
    out_out_of_range <= j2_r;
    if (j2_r) begin
      out_node_x <= '0;
      out_node_y <= '0;
      out_node_z <= '0;
      out_weight <= '0;
      out_grad_x <= '0;
      out_grad_y <= '0;
      out_grad_z <= '0;
    end else begin
      out_node_x <= n2x_r;
      out_node_y <= n2y_r;
      out_node_z <= n2z_r;
      if (rw2 < 0) out_weight <= '0;
      else if (rw2 > W_MAX) out_weight <= (FB + 1)'(W_MAX);
      else out_weight <= (FB + 1)'(rw2);
      out_grad_x <= (FB + 3)'(sat_g(rgx2));
      out_grad_y <= (FB + 3)'(sat_g(rgy2));
      out_grad_z <= (FB + 3)'(sat_g(rgz2));
    end
  end

  assign out_valid = v3_r;
  assign status    = {|oor_a, cnt_w, v1_r | v2_r};

endmodule
`default_nettype wire
